FILE: src/grb_pkg.sv
// Shared constants, register indexes and control types of the greedy row balancer.
// No dependencies; every other file of the block depends on this package.
`timescale 1ns / 1ps
`default_nettype none

package grb_pkg;

    localparam int MAX_ROWS  = 16;
    localparam int ROW_IDX_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int ROW_CNT_W = $clog2(MAX_ROWS + 1);

    localparam int WIDTH_W   = 12;
    localparam int LOAD_W    = 21;
    localparam int PAD_W     = 8;
    localparam int ROWS_W    = 5;
    localparam int RIDX_W    = 4;
    localparam int SUM_W     = LOAD_W + 2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_PADDING     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IN_USE = 2'd1;

    localparam logic [LOAD_W-1:0] LOAD_MAX = {LOAD_W{1'b1}};

    typedef struct packed {
        logic load_item;
        logic scan_step;
        logic commit;
    } t_ctl_cmd;

    typedef struct packed {
        logic scan_last;
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

FILE: src/grb_item_if.sv
// Input channel of the greedy row balancer: one beat carries one item.
// Depends on grb_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface grb_item_if;
    logic                          valid;
    logic                          ready;
    logic [grb_pkg::WIDTH_W-1:0]   item_width;
    logic                          last_item;

    modport source (output valid, output item_width, output last_item, input ready);
    modport sink   (input valid, input item_width, input last_item, output ready);
endinterface

`default_nettype wire

FILE: src/grb_result_if.sv
// Result channel of the greedy row balancer: one beat carries one placement.
// Depends on grb_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface grb_result_if;
    logic                          valid;
    logic                          ready;
    logic [grb_pkg::RIDX_W-1:0]    row_index;
    logic [grb_pkg::LOAD_W-1:0]    row_load;
    logic [grb_pkg::LOAD_W-1:0]    max_load;
    logic                          set_done;

    modport source (output valid, output row_index, output row_load, output max_load,
                    output set_done, input ready);
    modport sink   (input valid, input row_index, input row_load, input max_load,
                    input set_done, output ready);
endinterface

`default_nettype wire

FILE: src/grb_ctrl.sv
// Controller of the greedy row balancer: sequences accept, row scan and commit.
// Depends on grb_pkg for the command and status types.
`timescale 1ns / 1ps
`default_nettype none

module grb_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  grb_pkg::t_dp_status  i_status,
    output grb_pkg::t_ctl_cmd    o_cmd
);
    import grb_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_COMMIT = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state         = r_state;
        o_cmd.load_item = 1'b0;
        o_cmd.scan_step = 1'b0;
        o_cmd.commit    = 1'b0;
        o_in_ready      = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_status.scan_last) begin
                    n_state = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                // hold until the output register can take the result
                if (i_status.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

FILE: src/grb_datapath.sv
// Datapath of the greedy row balancer: config registers, row loads, scan unit, result register.
// Depends on grb_pkg and the result channel interface.
`timescale 1ns / 1ps
`default_nettype none

module grb_datapath (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_cfg_we,
    input  wire  [grb_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire  [grb_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  wire  [grb_pkg::WIDTH_W-1:0]        i_item_width,
    input  wire                                i_last_item,
    input  grb_pkg::t_ctl_cmd                  i_cmd,
    output grb_pkg::t_dp_status                o_status,
    grb_result_if.source                       o_result
);
    import grb_pkg::*;

    // configuration
    logic [PAD_W-1:0]     r_pad;
    logic [ROWS_W-1:0]    r_rows;

    // row loads; an entry without its valid bit reads as padding
    logic [LOAD_W-1:0]    r_row [MAX_ROWS];
    logic [MAX_ROWS-1:0]  r_vld;
    logic [LOAD_W-1:0]    r_max;
    logic                 r_max_vld;

    // item and scan state
    logic [WIDTH_W-1:0]   r_width;
    logic                 r_last;
    logic [ROW_CNT_W-1:0] r_scan;
    logic [ROW_IDX_W-1:0] r_best;
    logic [LOAD_W-1:0]    r_best_load;

    // result register
    logic                 r_out_vld;
    logic [RIDX_W-1:0]    r_out_idx;
    logic [LOAD_W-1:0]    r_out_load;
    logic [LOAD_W-1:0]    r_out_max;
    logic                 r_out_done;

    logic [LOAD_W-1:0]        pad_load;
    logic [ROW_CNT_W+4:0]     rows_ext;
    logic [ROW_CNT_W-1:0]     active;
    logic [ROW_IDX_W-1:0]     scan_idx;
    logic [LOAD_W-1:0]        rd_load;
    logic                     rd_less;
    logic [SUM_W-1:0]         sum;
    logic [LOAD_W-1:0]        new_load;
    logic [LOAD_W-1:0]        cur_max;
    logic [LOAD_W-1:0]        new_max;
    logic [ROW_IDX_W+RIDX_W-1:0] best_ext;
    logic                     cfg_hit;

    assign pad_load = LOAD_W'(r_pad);

    // clamp the row count into 1..MAX_ROWS
    assign rows_ext = (ROW_CNT_W + 5)'(r_rows);
    always_comb begin
        if (rows_ext == '0) begin
            active = ROW_CNT_W'(1);
        end else if (rows_ext > (ROW_CNT_W + 5)'(MAX_ROWS)) begin
            active = ROW_CNT_W'(MAX_ROWS);
        end else begin
            active = rows_ext[ROW_CNT_W-1:0];
        end
    end

    assign scan_idx = r_scan[ROW_IDX_W-1:0];
    assign rd_load  = r_vld[scan_idx] ? r_row[scan_idx] : pad_load;
    assign rd_less  = rd_load < r_best_load;

    assign sum      = SUM_W'(r_best_load) + SUM_W'(r_width) + SUM_W'(r_pad);
    assign new_load = (sum > SUM_W'(LOAD_MAX)) ? LOAD_MAX : sum[LOAD_W-1:0];
    assign cur_max  = r_max_vld ? r_max : pad_load;
    assign new_max  = (new_load > cur_max) ? new_load : cur_max;
    assign best_ext = (ROW_IDX_W + RIDX_W)'(r_best);

    assign cfg_hit = i_cfg_we && ((i_cfg_idx == CFG_PADDING) || (i_cfg_idx == CFG_ROWS_IN_USE));

    assign o_status.scan_last = (r_scan == active - ROW_CNT_W'(1));
    assign o_status.out_free  = !r_out_vld || o_result.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pad     <= '0;
            r_rows    <= ROWS_W'(1);
            r_vld     <= '0;
            r_max_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_we && (i_cfg_idx == CFG_PADDING)) begin
                r_pad <= i_cfg_data[PAD_W-1:0];
            end
            if (i_cfg_we && (i_cfg_idx == CFG_ROWS_IN_USE)) begin
                r_rows <= i_cfg_data[ROWS_W-1:0];
            end
            // a write of padding or rows_in_use restarts the set, as does the last item
            if (cfg_hit) begin
                r_vld     <= '0;
                r_max_vld <= 1'b0;
            end else if (i_cmd.commit) begin
                if (r_last) begin
                    r_vld     <= '0;
                    r_max_vld <= 1'b0;
                end else begin
                    r_vld[r_best] <= 1'b1;
                    r_max_vld     <= 1'b1;
                end
            end
            if (i_cmd.commit) begin
                r_out_vld <= 1'b1;
            end else if (o_result.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_width     <= i_item_width;
            r_last      <= i_last_item;
            r_scan      <= '0;
            r_best      <= '0;
            r_best_load <= LOAD_MAX;
        end
        if (i_cmd.scan_step) begin
            r_scan <= r_scan + ROW_CNT_W'(1);
            if (rd_less) begin
                r_best      <= scan_idx;
                r_best_load <= rd_load;
            end
        end
        if (i_cmd.commit) begin
            r_row[r_best] <= new_load;
            r_max         <= new_max;
            r_out_idx     <= best_ext[RIDX_W-1:0];
            r_out_load    <= new_load;
            r_out_max     <= new_max;
            r_out_done    <= r_last;
        end
    end

    assign o_result.valid     = r_out_vld;
    assign o_result.row_index = r_out_idx;
    assign o_result.row_load  = r_out_load;
    assign o_result.max_load  = r_out_max;
    assign o_result.set_done  = r_out_done;

endmodule

`default_nettype wire

FILE: src/greedy_row_balancer_core.sv
// Top level of the greedy row balancer: joins the controller and the datapath.
// Depends on grb_pkg, grb_item_if, grb_result_if, grb_ctrl and grb_datapath.
`timescale 1ns / 1ps
`default_nettype none

// Greedy row balancer. Each item beat on i_item is placed into the least-loaded
// of the rows in use (lowest index on a tie); that row grows by item_width plus
// padding, saturating at 2097151, and one result beat on o_result reports the
// row, its new load, the largest load of the set and whether the set is closed.
// Every row starts a set at the padding value; the item marked last_item, and
// any write of padding (index 0) or rows_in_use (index 1, clamped to 1..16),
// starts a new set. Write configuration only while no item is in flight.
// Items are handled one at a time: an item is accepted in idle, the scan then
// reads one row load per cycle through a single comparator, and the commit ends
// the item. The result sits in an output register, so the next item is accepted
// while a result waits; the block stalls only when a finished result meets a
// still-full output register.
module greedy_row_balancer_core (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_cfg_we,
    input  wire  [grb_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire  [grb_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    grb_item_if.sink                        i_item,
    grb_result_if.source                    o_result
);
    import grb_pkg::*;

    t_ctl_cmd   ctl_cmd;
    t_dp_status dp_status;

    // sequencing: accept in idle, scan the rows, commit when the output is free
    grb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .o_in_ready (i_item.ready),
        .i_status   (dp_status),
        .o_cmd      (ctl_cmd)
    );

    // row loads, minimum search, saturating add and result register
    grb_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_item_width (i_item.item_width),
        .i_last_item  (i_item.last_item),
        .i_cmd        (ctl_cmd),
        .o_status     (dp_status),
        .o_result     (o_result)
    );

endmodule

`default_nettype wire

FILE: src/grb_checker.sv
// Port-level checker of the greedy row balancer, bound to the top level.
// Depends on grb_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

module grb_checker (
    input wire                           i_clk,
    input wire                           i_rst_n,
    input wire                           i_in_valid,
    input wire                           i_in_ready,
    input wire                           i_out_valid,
    input wire                           i_out_ready,
    input wire [grb_pkg::RIDX_W-1:0]     i_row_index,
    input wire [grb_pkg::LOAD_W-1:0]     i_row_load,
    input wire [grb_pkg::LOAD_W-1:0]     i_max_load,
    input wire                           i_set_done
);
    import grb_pkg::*;

    // a stalled result beat stays up
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result beat dropped while stalled");

    // a stalled result beat keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_row_index) && $stable(i_row_load) &&
            $stable(i_max_load) && $stable(i_set_done))
        else $error("result payload changed while stalled");

    // one item at a time: the scan follows every accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input accepted again during the row scan");

    // the set maximum covers the row just loaded
    a_max_covers_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_row_load <= i_max_load)
        else $error("row load above the set maximum");

endmodule

bind greedy_row_balancer_core grb_checker u_grb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_item.valid),
    .i_in_ready  (i_item.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_row_index (o_result.row_index),
    .i_row_load  (o_result.row_load),
    .i_max_load  (o_result.max_load),
    .i_set_done  (o_result.set_done)
);

`default_nettype wire
